// ----- hw/rtl/dhtpfd_pkg.sv -----
package dhtpfd_pkg;

  localparam int unsigned NumBytes  = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [7:0] PulseFirstStart = 8'd3;
  localparam logic [7:0] PulseLastStart  = 8'd4;
  localparam logic [7:0] PulseLastData   = 8'd84;
  localparam logic [7:0] PulseTooMany    = 8'd86;

  localparam logic [15:0] StartMinRst  = 16'd400;
  localparam logic [15:0] StartMaxRst  = 16'd450;
  localparam logic [15:0] PulseMinRst  = 16'd100;
  localparam logic [15:0] PulseMaxRst  = 16'd400;
  localparam logic [15:0] GapMinRst    = 16'd250;
  localparam logic [15:0] GapMaxRst    = 16'd300;
  localparam logic [15:0] ZeroBelowRst = 16'd150;
  localparam logic [15:0] OneAboveRst  = 16'd300;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_BAD_WIDTH = 3'd3,
    ST_BAD_GAP   = 3'd4,
    ST_BAD_BIT   = 3'd5,
    ST_CHECKSUM  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CMD_PULSE = 2'd0,
    CMD_START = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MIN  = 3'd0,
    CFG_START_MAX  = 3'd1,
    CFG_PULSE_MIN  = 3'd2,
    CFG_PULSE_MAX  = 3'd3,
    CFG_GAP_MIN    = 3'd4,
    CFG_GAP_MAX    = 3'd5,
    CFG_ZERO_BELOW = 3'd6,
    CFG_ONE_ABOVE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] start_min;
    logic [15:0] start_max;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
    logic [15:0] gap_min;
    logic [15:0] gap_max;
    logic [15:0] zero_below;
    logic [15:0] one_above;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  pulse_cnt;
    logic [5:0]  bit_cnt;
    logic [NumBytes-1:0][7:0] data;
  } state_t;

  typedef struct packed {
    logic start_accepted;
    logic frame_done;
  } flags_t;

endpackage

// ----- hw/rtl/dhtpfd_if.sv -----
interface dhtpfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] pulse_width;

  modport source (output valid, output command, output pulse_width, input ready);
  modport sink   (input valid, input command, input pulse_width, output ready);
endinterface

interface dhtpfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       error_flag;
  logic       start_accepted;
  logic       frame_done;
  logic [7:0] humidity_whole;
  logic [7:0] humidity_tenths;
  logic [7:0] temperature_whole;
  logic [7:0] temperature_tenths;
  logic [7:0] checksum_byte;

  modport source (
    output valid, output status, output error_flag, output start_accepted,
    output frame_done, output humidity_whole, output humidity_tenths,
    output temperature_whole, output temperature_tenths, output checksum_byte,
    input ready
  );
  modport sink (
    input valid, input status, input error_flag, input start_accepted,
    input frame_done, input humidity_whole, input humidity_tenths,
    input temperature_whole, input temperature_tenths, input checksum_byte,
    output ready
  );
endinterface

// ----- hw/rtl/dht_pulse_frame_decoder_unit.sv -----
// Pulse frame decoder for a single-wire humidity/temperature sensor.
// in_i carries one transaction per measured pulse or command (pulse, start,
// clear error). out_o returns exactly one result transaction per input
// transaction: the sticky status, error flag, start/frame-done strobes and
// the five data bytes as they stand after that transaction.
// A transaction accepted at one edge shows its result on out_o from the next
// cycle. One transaction is taken per cycle while out_o.ready is high; the
// decode is a single compare/shift/add pass between the state registers and
// the output register.
// When the receiver stalls, the result is held in the output register and
// in_i.ready drops until that result is taken; a transaction is still taken
// in the cycle the held result leaves.
// The cfg_* port writes the eight 16-bit window registers; write only while
// no result is pending. Reset restores the default windows, clears status,
// counters and data bytes, and empties the output register.
module dht_pulse_frame_decoder_unit #(
  parameter int unsigned MAX_PULSES = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dhtpfd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dhtpfd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  dhtpfd_in_if.sink                           in_i,
  dhtpfd_out_if.source                        out_o
);
  import dhtpfd_pkg::*;

  cfg_t   cfg_q;
  state_t st_q, st_d;
  flags_t flags;
  logic   in_fire;
  logic   out_valid_q;
  status_e     res_status_q;
  flags_t      res_flags_q;
  logic [NumBytes-1:0][7:0] res_data_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_min: StartMinRst, start_max: StartMaxRst,
                 pulse_min: PulseMinRst, pulse_max: PulseMaxRst,
                 gap_min: GapMinRst, gap_max: GapMaxRst,
                 zero_below: ZeroBelowRst, one_above: OneAboveRst};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_MIN:  cfg_q.start_min  <= cfg_wdata_i;
        CFG_START_MAX:  cfg_q.start_max  <= cfg_wdata_i;
        CFG_PULSE_MIN:  cfg_q.pulse_min  <= cfg_wdata_i;
        CFG_PULSE_MAX:  cfg_q.pulse_max  <= cfg_wdata_i;
        CFG_GAP_MIN:    cfg_q.gap_min    <= cfg_wdata_i;
        CFG_GAP_MAX:    cfg_q.gap_max    <= cfg_wdata_i;
        CFG_ZERO_BELOW: cfg_q.zero_below <= cfg_wdata_i;
        CFG_ONE_ABOVE:  cfg_q.one_above  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dhtpfd_step #(
    .MAX_PULSES(MAX_PULSES)
  ) u_step (
    .cfg_i         (cfg_q),
    .cur_i         (st_q),
    .command_i     (in_i.command),
    .pulse_width_i (in_i.pulse_width),
    .nxt_o         (st_d),
    .flags_o       (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{status: ST_OK, pulse_cnt: '0, bit_cnt: '0, data: '0};
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_status_q <= st_d.status;
      res_flags_q  <= flags;
      res_data_q   <= st_d.data;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.status             = res_status_q;
  assign out_o.error_flag         = (res_status_q != ST_OK);
  assign out_o.start_accepted     = res_flags_q.start_accepted;
  assign out_o.frame_done         = res_flags_q.frame_done;
  assign out_o.humidity_whole     = res_data_q[0];
  assign out_o.humidity_tenths    = res_data_q[1];
  assign out_o.temperature_whole  = res_data_q[2];
  assign out_o.temperature_tenths = res_data_q[3];
  assign out_o.checksum_byte      = res_data_q[4];

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pulse_cnt <= 8'(MAX_PULSES))
    else $error("pulse count beyond limit");

  a_err_holds_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && st_q.status != ST_OK) |=> $stable(st_q.pulse_cnt))
    else $error("pulse count moved while in error");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.command == CMD_START && st_q.status == ST_OK)
      |=> (st_q.pulse_cnt == '0 && st_q.bit_cnt == '0 && out_o.start_accepted))
    else $error("accepted start did not clear counters");

  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_done)
      |-> (out_o.status == ST_OK && !out_o.start_accepted))
    else $error("frame done with bad status or start");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(res_data_q)))
    else $error("stalled result changed");

endmodule

// ----- hw/rtl/dhtpfd_step.sv -----
module dhtpfd_step #(
  parameter int unsigned MAX_PULSES = 128
) (
  input  dhtpfd_pkg::cfg_t   cfg_i,
  input  dhtpfd_pkg::state_t cur_i,
  input  logic [1:0]         command_i,
  input  logic [15:0]        pulse_width_i,
  output dhtpfd_pkg::state_t nxt_o,
  output dhtpfd_pkg::flags_t flags_o
);
  import dhtpfd_pkg::*;

  logic [7:0]  n;
  logic [15:0] w;
  logic [2:0]  byte_idx;
  logic        bit_ok;
  logic        bit_val;
  logic [7:0]  sum;
  state_t      nxt;
  flags_t      flags;

  assign n        = cur_i.pulse_cnt;
  assign w        = pulse_width_i;
  assign byte_idx = cur_i.bit_cnt[5:3];

  always_comb begin
    bit_ok  = 1'b0;
    bit_val = 1'b0;
    if (w < cfg_i.zero_below) begin
      bit_ok = 1'b1;
    end else if (w > cfg_i.one_above) begin
      bit_ok  = 1'b1;
      bit_val = 1'b1;
    end
  end

  always_comb begin
    nxt   = cur_i;
    flags = '0;
    sum   = '0;
    case (cmd_e'(command_i))
      CMD_PULSE: begin
        if (cur_i.status == ST_OK && n < 8'(MAX_PULSES)) begin
          nxt.pulse_cnt = n + 8'd1;
          if (n < PulseFirstStart) begin
            nxt.status = ST_OK;
          end else if (n <= PulseLastStart) begin
            if (w < cfg_i.start_min || w > cfg_i.start_max) nxt.status = ST_BAD_START;
          end else if (n >= PulseTooMany) begin
            nxt.status = ST_TOO_MANY;
          end else if (w > cfg_i.pulse_max || w < cfg_i.pulse_min) begin
            nxt.status = ST_BAD_WIDTH;
          end else if (n[0]) begin
            if (w < cfg_i.gap_min || w > cfg_i.gap_max) nxt.status = ST_BAD_GAP;
          end else if (!bit_ok) begin
            nxt.status = ST_BAD_BIT;
          end else begin
            for (int i = 0; i < NumBytes; i++) begin
              if (byte_idx == 3'(i)) nxt.data[i] = {cur_i.data[i][6:0], bit_val};
            end
            nxt.bit_cnt = cur_i.bit_cnt + 6'd1;
            if (n == PulseLastData) begin
              sum = nxt.data[0] + nxt.data[1] + nxt.data[2] + nxt.data[3];
              if (sum != nxt.data[4]) begin
                nxt.status = ST_CHECKSUM;
              end else begin
                flags.frame_done = 1'b1;
              end
            end
          end
        end
      end
      CMD_START: begin
        if (cur_i.status == ST_OK) begin
          nxt.pulse_cnt        = '0;
          nxt.bit_cnt          = '0;
          flags.start_accepted = 1'b1;
        end
      end
      CMD_CLEAR: nxt.status = ST_OK;
      default: ;
    endcase
  end

  assign nxt_o   = nxt;
  assign flags_o = flags;

endmodule

// ----- sim/dht_pulse_frame_decoder_unit_test.sv -----
`timescale 1ns / 100ps

module dht_pulse_frame_decoder_unit_test;
  import dhtpfd_pkg::*;

  localparam int unsigned MaxPulses     = 128;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned FramePhaseMin = 80;
  localparam int unsigned NoiseItems    = 45;

  typedef enum int unsigned {
    WIN_RESET,
    WIN_RANDOM,
    WIN_WIDE,
    WIN_ZERO,
    WIN_ONES
  } win_kind_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] width;
    logic        typed;
    status_e     t_status;
    logic        t_start;
    logic        t_done;
  } stim_t;

  typedef struct packed {
    status_e                  status;
    logic                     error_flag;
    logic                     start_accepted;
    logic                     frame_done;
    logic [NumBytes-1:0][7:0] data;
  } decode_res_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  cfg_idx_e            cfg_idx   = CFG_START_MIN;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                drv_valid = 1'b0;
  stim_t               drv       = '0;
  logic                out_rdy   = 1'b0;

  dhtpfd_in_if  in_bus ();
  dhtpfd_out_if out_bus ();

  assign in_bus.valid       = drv_valid;
  assign in_bus.command     = drv.cmd;
  assign in_bus.pulse_width = drv.width;
  assign out_bus.ready      = out_rdy;

  dht_pulse_frame_decoder_unit #(
    .MAX_PULSES(MaxPulses)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  cfg_t        win;
  status_e     dec_st;
  logic [7:0]  pulse_no;
  logic [5:0]  bit_no;
  logic [7:0]  rx_bytes [NumBytes];
  decode_res_t decoded_q [$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_cnt     = 0;
  int unsigned accepted_in  = 0;
  int unsigned frames_ok    = 0;
  int unsigned starts_ok    = 0;
  logic [6:0]  status_seen  = '0;
  int unsigned idle_in      = 0;
  int unsigned stall_out    = 0;
  int unsigned hold_len     = 0;

  stim_t dir_tab [26] = '{
    '{CMD_NONE,  16'hFFFF, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'h0000, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'hFFFF, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'h0000, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd400,  1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd451,  1'b1, ST_BAD_START, 1'b0, 1'b0},
    '{CMD_PULSE, 16'd425,  1'b1, ST_BAD_START, 1'b0, 1'b0},
    '{CMD_START, 16'h0000, 1'b1, ST_BAD_START, 1'b0, 1'b0},
    '{CMD_CLEAR, 16'h0000, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_START, 16'hFFFF, 1'b1, ST_OK,        1'b1, 1'b0},
    '{CMD_PULSE, 16'h5555, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'hAAAA, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'h0000, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd450,  1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd400,  1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd250,  1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd100,  1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd300,  1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd400,  1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd249,  1'b1, ST_BAD_GAP,   1'b0, 1'b0},
    '{CMD_CLEAR, 16'h0000, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd150,  1'b1, ST_BAD_BIT,   1'b0, 1'b0},
    '{CMD_CLEAR, 16'hFFFF, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd401,  1'b1, ST_BAD_WIDTH, 1'b0, 1'b0},
    '{CMD_CLEAR, 16'h0000, 1'b1, ST_OK,        1'b0, 1'b0},
    '{CMD_PULSE, 16'd99,   1'b1, ST_BAD_WIDTH, 1'b0, 1'b0}
  };

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic judge_pulse(logic [7:0] n, logic [15:0] w);
    logic [2:0] idx;
    logic [7:0] sum;
    idx = bit_no[5:3];
    if (n < PulseFirstStart) return 1'b0;
    if (n <= PulseLastStart) begin
      if (w < win.start_min || w > win.start_max) dec_st = ST_BAD_START;
      return 1'b0;
    end
    if (n >= PulseTooMany) begin
      dec_st = ST_TOO_MANY;
      return 1'b0;
    end
    if (w < win.pulse_min || w > win.pulse_max) begin
      dec_st = ST_BAD_WIDTH;
      return 1'b0;
    end
    if (n[0]) begin
      if (w < win.gap_min || w > win.gap_max) dec_st = ST_BAD_GAP;
      return 1'b0;
    end
    if (w < win.zero_below) begin
      if (idx < NumBytes) rx_bytes[idx] = {rx_bytes[idx][6:0], 1'b0};
    end else if (w > win.one_above) begin
      if (idx < NumBytes) rx_bytes[idx] = {rx_bytes[idx][6:0], 1'b1};
    end else begin
      dec_st = ST_BAD_BIT;
      return 1'b0;
    end
    bit_no = bit_no + 6'd1;
    if (n != PulseLastData) return 1'b0;
    sum = rx_bytes[0] + rx_bytes[1] + rx_bytes[2] + rx_bytes[3];
    if (sum != rx_bytes[4]) begin
      dec_st = ST_CHECKSUM;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic decode_res_t decode_item(cmd_e c, logic [15:0] w);
    decode_res_t r;
    r = '0;
    case (c)
      CMD_PULSE: begin
        if (dec_st == ST_OK && pulse_no < MaxPulses) begin
          r.frame_done = judge_pulse(pulse_no, w);
          pulse_no = pulse_no + 8'd1;
        end
      end
      CMD_START: begin
        if (dec_st == ST_OK) begin
          pulse_no = '0;
          bit_no = '0;
          r.start_accepted = 1'b1;
        end
      end
      CMD_CLEAR: dec_st = ST_OK;
      default: ;
    endcase
    r.status = dec_st;
    r.error_flag = (dec_st != ST_OK);
    for (int i = 0; i < NumBytes; i++) r.data[i] = rx_bytes[i];
    return r;
  endfunction

  function automatic stim_t plain_item(cmd_e c, logic [15:0] w);
    stim_t s;
    s = '0;
    s.cmd = c;
    s.width = w;
    return s;
  endfunction

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    decode_res_t want;
    logic moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending, status %0d", $time, out_bus.status);
        end else begin
          want = decoded_q.pop_front();
          check_field("status", 8'(want.status), 8'(out_bus.status));
          check_field("error_flag", 8'(want.error_flag), 8'(out_bus.error_flag));
          check_field("start_accepted", 8'(want.start_accepted),
                      8'(out_bus.start_accepted));
          check_field("frame_done", 8'(want.frame_done), 8'(out_bus.frame_done));
          check_field("humidity_whole", want.data[0], out_bus.humidity_whole);
          check_field("humidity_tenths", want.data[1], out_bus.humidity_tenths);
          check_field("temperature_whole", want.data[2], out_bus.temperature_whole);
          check_field("temperature_tenths", want.data[3], out_bus.temperature_tenths);
          check_field("checksum_byte", want.data[4], out_bus.checksum_byte);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        want = decode_item(drv.cmd, drv.width);
        if (drv.typed) begin
          want.status = drv.t_status;
          want.error_flag = (drv.t_status != ST_OK);
          want.start_accepted = drv.t_start;
          want.frame_done = drv.t_done;
        end
        status_seen[want.status] = 1'b1;
        frames_ok += 32'(want.frame_done);
        starts_ok += 32'(want.start_accepted);
        accepted_in++;
        decoded_q.push_back(want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("[dht_pulse_frame_decoder_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_rdy <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
      end else begin
        out_rdy <= ($urandom_range(99, 0) >= stall_out);
      end
    end
  end

  task automatic send(stim_t s);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < idle_in) begin
      drv_valid <= 1'b0;
      @(negedge clk_i);
    end
    drv_valid <= 1'b1;
    drv <= s;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    drv_valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
  endtask

  task automatic program_windows(cfg_t c);
    write_reg(CFG_START_MIN, c.start_min);
    write_reg(CFG_START_MAX, c.start_max);
    write_reg(CFG_PULSE_MIN, c.pulse_min);
    write_reg(CFG_PULSE_MAX, c.pulse_max);
    write_reg(CFG_GAP_MIN, c.gap_min);
    write_reg(CFG_GAP_MAX, c.gap_max);
    write_reg(CFG_ZERO_BELOW, c.zero_below);
    write_reg(CFG_ONE_ABOVE, c.one_above);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    win = c;
  endtask

  // Send an optional clear, a start and one frame, optionally corrupted, then optional surplus pulses.
  task automatic run_frame(bit long_tail);
    logic [7:0]  fb [NumBytes];
    int          bad_slot;
    int          extra;
    int          k;
    logic        one;
    logic [15:0] w;
    logic [2:0]  byte_sel;
    logic [2:0]  bit_sel;
    if (long_tail || $urandom_range(9, 0) != 0) send(plain_item(CMD_CLEAR, 16'($urandom)));
    send(plain_item(CMD_START, 16'($urandom)));
    for (int i = 0; i < 4; i++) fb[i] = 8'($urandom);
    fb[4] = fb[0] + fb[1] + fb[2] + fb[3];
    if ($urandom_range(5, 0) == 0) fb[4] = fb[4] ^ 8'($urandom_range(255, 1));
    bad_slot = ($urandom_range(3, 0) == 0) ? int'($urandom_range(84, 0)) : -1;
    extra = ($urandom_range(4, 0) == 0) ? int'($urandom_range(50, 1)) : 0;
    if (long_tail) begin
      bad_slot = -1;
      extra = 2;
    end
    for (int n = 0; n <= int'(PulseLastData) + extra; n++) begin
      k = (n - 6) / 2;
      if (n == bad_slot || n < PulseFirstStart) begin
        w = 16'($urandom);
      end else if (n <= PulseLastStart) begin
        w = 16'($urandom_range(win.start_max, win.start_min));
      end else if (n % 2 == 1) begin
        w = 16'($urandom_range(win.gap_max, win.gap_min));
      end else begin
        if (n <= PulseLastData) begin
          byte_sel = 3'(k / 8);
          bit_sel = 3'(7 - k % 8);
          one = fb[byte_sel][bit_sel];
        end else begin
          one = 1'($urandom);
        end
        if (one) w = 16'($urandom_range(win.pulse_max, 32'(win.one_above) + 1));
        else w = 16'($urandom_range(32'(win.zero_below) - 1, win.pulse_min));
      end
      send(plain_item(CMD_PULSE, w));
    end
    if (long_tail) begin
      // walk the counter up to its ceiling
      repeat (45) begin
        send(plain_item(CMD_CLEAR, 16'($urandom)));
        send(plain_item(CMD_PULSE, 16'($urandom)));
      end
    end else if (extra != 0 && $urandom_range(1, 0) == 1) begin
      send(plain_item(CMD_CLEAR, 16'($urandom)));
      repeat (2) send(plain_item(CMD_PULSE, 16'($urandom)));
    end
  endtask

  initial begin
    int unsigned phase_start;
    cfg_t        c;
    win_kind_e   kind;
    int unsigned pmin, zb, oa, pmx, gmn, smn;
    int unsigned r, k;
    cmd_e        nc;
    logic [15:0] nw;

    dec_st = ST_OK;
    pulse_no = '0;
    bit_no = '0;
    foreach (rx_bytes[i]) rx_bytes[i] = '0;
    win = '{StartMinRst, StartMaxRst, PulseMinRst, PulseMaxRst,
            GapMinRst, GapMaxRst, ZeroBelowRst, OneAboveRst};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send(dir_tab[i]);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p % 4)
        0: begin
          idle_in = 0;
          stall_out = 0;
        end
        1: begin
          idle_in = 57;
          stall_out = 0;
        end
        2: begin
          idle_in = 0;
          stall_out = 57;
        end
        default: begin
          idle_in = 11;
          stall_out = 11;
        end
      endcase
      case (p)
        0, 7: kind = WIN_RESET;
        2: kind = WIN_WIDE;
        3: kind = WIN_ZERO;
        5: kind = WIN_ONES;
        default: kind = WIN_RANDOM;
      endcase
      case (kind)
        WIN_RESET: c = '{StartMinRst, StartMaxRst, PulseMinRst, PulseMaxRst,
                         GapMinRst, GapMaxRst, ZeroBelowRst, OneAboveRst};
        WIN_WIDE: c = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                        16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
        WIN_ZERO: c = '0;
        WIN_ONES: c = '1;
        default: begin
          pmin = $urandom_range(3000, 0);
          zb = pmin + 1 + $urandom_range(500, 0);
          oa = zb + $urandom_range(600, 0);
          pmx = oa + 1 + $urandom_range(600, 0);
          gmn = $urandom_range(pmx, pmin);
          smn = $urandom_range(65000, 0);
          c = '{16'(smn), 16'(smn + $urandom_range(535, 0)), 16'(pmin), 16'(pmx),
                16'(gmn), 16'($urandom_range(pmx, gmn)), 16'(zb), 16'(oa)};
        end
      endcase
      program_windows(c);
      phase_start = sent_cnt;
      if (kind == WIN_ZERO || kind == WIN_ONES) begin
        repeat (NoiseItems) begin
          r = $urandom_range(9, 0);
          nc = (r < 7) ? CMD_PULSE : (r == 7) ? CMD_START : (r == 8) ? CMD_CLEAR : CMD_NONE;
          case ($urandom_range(3, 0))
            0: nw = 16'($urandom);
            1: nw = ($urandom_range(1, 0) == 1) ? 16'hFFFF : 16'h0000;
            2: begin
              k = $urandom_range(7, 0);
              nw = win[{k[2:0], 4'd0} +: 16] + 16'($urandom_range(2, 0)) - 16'd1;
            end
            default: nw = 16'($urandom_range(600, 0));
          endcase
          send(plain_item(nc, nw));
        end
      end else begin
        // in phase 0, stall the output so the block fills and backs up the input
        if (p == 0) hold_len = HoldOffCycles;
        while (sent_cnt - phase_start < FramePhaseMin) begin
          run_frame(p == 4 && sent_cnt == phase_start);
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    $display("Decoded %0d transactions over eight window settings and four idle mixes;",
             accepted_in);
    $display("%0d frames completed, %0d starts taken, status codes reached %b.",
             frames_ok, starts_ok, status_seen);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("[dht_pulse_frame_decoder_unit] OK");
    end else begin
      $display("[dht_pulse_frame_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule
